// File: hdl/dlr_pkg.sv
// Shared types and constants for the DDA line rasterizer.
`default_nettype none
package dlr_pkg;

  localparam int COLOR_BITS = 24;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFF0000;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SLOPE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;       // load a new line and emit its start pixel
    logic advance;     // step the active line and emit a pixel
    logic div_step;    // one restoring division step
    logic slope_load;  // write the signed slope from the quotient
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic amaj_zero;   // the offered start word describes a zero-length line
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: controller, datapath and ports.
// A result word is offered in the cycle after its input word is accepted.
// Advance words run at one per cycle while the output is taken; a nonzero-length start
// word holds the input while the one-bit-per-cycle slope divider runs and the slope is
// loaded; a zero-length start does not. Configuration writes are taken every cycle.
// Reset (rst_n low, synchronous) idles the controller, drops the active line and
// sets the pixel color to 0xFF0000.
`default_nettype none
module dda_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_opcode,
  input  wire logic [COORD_BITS-1:0]          in_x_start,
  input  wire logic [COORD_BITS-1:0]          in_y_start,
  input  wire logic [COORD_BITS-1:0]          in_x_end,
  input  wire logic [COORD_BITS-1:0]          in_y_end,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_pixel_valid,
  output logic [COORD_BITS-1:0]               out_pixel_x,
  output logic [COORD_BITS-1:0]               out_pixel_y,
  output logic [dlr_pkg::COLOR_BITS-1:0]      out_pixel_color_res,
  output logic                                out_last_pixel,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dlr_pkg::COLOR_BITS-1:0] cfg_pixel_color
);

  dlr_pkg::cmd_t  cmd;
  dlr_pkg::stat_t stat;

  // Color register accepts a write every cycle
  assign cfg_ready = 1'b1;

  dlr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_x_start          (in_x_start),
    .in_y_start          (in_y_start),
    .in_x_end            (in_x_end),
    .in_y_end            (in_y_end),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_pixel_color     (cfg_pixel_color),
    .out_pixel_valid     (out_pixel_valid),
    .out_pixel_x         (out_pixel_x),
    .out_pixel_y         (out_pixel_y),
    .out_pixel_color_res (out_pixel_color_res),
    .out_last_pixel      (out_last_pixel)
  );

endmodule
`default_nettype wire

// File: hdl/dlr_ctrl.sv
// Controller state machine for the DDA line rasterizer.
`default_nettype none
module dlr_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_opcode,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire dlr_pkg::stat_t stat,
  output dlr_pkg::cmd_t      cmd
);

  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);

  dlr_pkg::state_t     state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == dlr_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      dlr_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          if (in_opcode == dlr_pkg::OP_START) begin
            cmd.start = 1'b1;
            if (!stat.amaj_zero) begin
              state_nxt = dlr_pkg::ST_DIV;
              cnt_nxt   = '0;
            end
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      dlr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = dlr_pkg::ST_SLOPE;
        end
      end
      dlr_pkg::ST_SLOPE: begin
        cmd.slope_load = 1'b1;
        state_nxt      = dlr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dlr_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dlr_pkg::ST_IDLE) |-> !in_ready)
    else $error("input taken while slope division runs");

  a_div_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == dlr_pkg::OP_START && !stat.amaj_zero)
      |=> (state_r == dlr_pkg::ST_DIV && cnt_r == '0))
    else $error("nonzero line start did not begin division");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dlr_pkg::ST_DIV && cnt_r == CNT_LAST) |=> (state_r == dlr_pkg::ST_SLOPE))
    else $error("division did not end after its last step");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule
`default_nettype wire

// File: hdl/dlr_datapath.sv
// Datapath of the DDA line rasterizer: line state, slope divider, output register.
`default_nettype none
module dlr_datapath #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dlr_pkg::cmd_t                 cmd,
  output dlr_pkg::stat_t                     stat,
  input  wire logic [COORD_BITS-1:0]         in_x_start,
  input  wire logic [COORD_BITS-1:0]         in_y_start,
  input  wire logic [COORD_BITS-1:0]         in_x_end,
  input  wire logic [COORD_BITS-1:0]         in_y_end,
  input  wire logic                          cfg_we,
  input  wire logic [dlr_pkg::COLOR_BITS-1:0] cfg_pixel_color,
  output logic                               out_pixel_valid,
  output logic [COORD_BITS-1:0]              out_pixel_x,
  output logic [COORD_BITS-1:0]              out_pixel_y,
  output logic [dlr_pkg::COLOR_BITS-1:0]     out_pixel_color_res,
  output logic                               out_last_pixel
);

  localparam int C          = COORD_BITS;
  localparam int SLOPE_BITS = FRAC_BITS + 2;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 2;
  localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

  // Line state
  logic                      major_is_x_r;
  logic [C-1:0]              major_coord_r;
  logic [C-1:0]              major_end_r;
  logic                      step_neg_r;
  logic                      minor_neg_r;
  logic [ACC_BITS-1:0]       acc_r;
  logic [SLOPE_BITS-1:0]     slope_r;
  logic                      line_active_r;
  logic [dlr_pkg::COLOR_BITS-1:0] color_r;

  // Divider state
  logic [C-1:0]              amaj_r;
  logic [C:0]                rem_r;
  logic [FRAC_BITS:0]        quo_r;

  // Start word decode
  logic [C-1:0] adx, ady, amaj, amin, mstart, mend, nstart, nend;
  logic         maj_x;

  always_comb begin
    adx   = (in_x_end >= in_x_start) ? (in_x_end - in_x_start) : (in_x_start - in_x_end);
    ady   = (in_y_end >= in_y_start) ? (in_y_end - in_y_start) : (in_y_start - in_y_end);
    maj_x = (adx >= ady);
    if (maj_x) begin
      amaj = adx; amin = ady; mstart = in_x_start; mend = in_x_end;
      nstart = in_y_start; nend = in_y_end;
    end else begin
      amaj = ady; amin = adx; mstart = in_y_start; mend = in_y_end;
      nstart = in_x_start; nend = in_x_end;
    end
  end

  assign stat.amaj_zero = (amaj == '0);

  // Division step: compare, subtract, shift
  logic [C+1:0]          div_diff;
  logic                  div_ge;
  logic [C:0]            div_rem;
  always_comb begin
    div_diff = {1'b0, rem_r} - {2'b00, amaj_r};
    div_ge   = !div_diff[C+1];
    div_rem  = div_ge ? div_diff[C:0] : rem_r;
  end

  // Advance step
  logic [C-1:0]          major_nxt;
  logic [ACC_BITS-1:0]   acc_nxt, acc_round;
  logic [C-1:0]          minor_rnd;
  logic                  at_end;
  always_comb begin
    major_nxt = step_neg_r ? (major_coord_r - C'(1)) : (major_coord_r + C'(1));
    acc_nxt   = acc_r + {{(ACC_BITS-SLOPE_BITS){slope_r[SLOPE_BITS-1]}}, slope_r};
    acc_round = acc_nxt + HALF;
    minor_rnd = acc_round[FRAC_BITS +: C];
    at_end    = (major_nxt == major_end_r);
  end

  // Control-like state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      color_r       <= dlr_pkg::COLOR_RESET;
    end else begin
      if (cfg_we) begin
        color_r <= cfg_pixel_color;
      end
      if (cmd.start) begin
        line_active_r <= !stat.amaj_zero;
      end else if (cmd.advance && line_active_r && at_end) begin
        line_active_r <= 1'b0;
      end
    end
  end

  // Line registers, divider and output word
  logic [SLOPE_BITS-1:0] slope_mag;
  assign slope_mag = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      major_is_x_r  <= maj_x;
      major_coord_r <= mstart;
      major_end_r   <= mend;
      step_neg_r    <= (mend < mstart);
      minor_neg_r   <= (nend < nstart);
      acc_r         <= ACC_BITS'(nstart) << FRAC_BITS;
      slope_r       <= '0;
      amaj_r        <= amaj;
      rem_r         <= {1'b0, amin};
      quo_r         <= '0;
      out_pixel_valid     <= 1'b1;
      out_pixel_x         <= in_x_start;
      out_pixel_y         <= in_y_start;
      out_pixel_color_res <= color_r;
      out_last_pixel      <= stat.amaj_zero;
    end
    if (cmd.div_step) begin
      rem_r <= {div_rem[C-1:0], 1'b0};
      quo_r <= {quo_r[FRAC_BITS-1:0], div_ge};
    end
    if (cmd.slope_load) begin
      slope_r <= minor_neg_r ? (SLOPE_BITS'(0) - slope_mag) : slope_mag;
    end
    if (cmd.advance) begin
      if (line_active_r) begin
        major_coord_r       <= major_nxt;
        acc_r               <= acc_nxt;
        out_pixel_valid     <= 1'b1;
        out_pixel_x         <= major_is_x_r ? major_nxt : minor_rnd;
        out_pixel_y         <= major_is_x_r ? minor_rnd : major_nxt;
        out_pixel_color_res <= color_r;
        out_last_pixel      <= at_end;
      end else begin
        out_pixel_valid     <= 1'b0;
        out_pixel_x         <= '0;
        out_pixel_y         <= '0;
        out_pixel_color_res <= '0;
        out_last_pixel      <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
